// ----- rtl/ocpu_pkg.sv -----
package ocpu_pkg;

	localparam int CORDIC_ITERATIONS_DEF = 16;
	localparam int ATAN_LEN              = 24;
	localparam int ITER_W                = 5;
	localparam int CFG_W                 = 17;
	localparam int LIN_STEP_W            = 17;
	localparam int ANG_STEP_W            = 14;
	localparam int MUL_STEPS             = 5;

	localparam logic [0:0] REG_LINEAR_STEP = 1'b0;
	localparam logic [0:0] REG_ANGLE_STEP  = 1'b1;

	localparam logic SEL_EL = 1'b0;
	localparam logic SEL_AZ = 1'b1;

	localparam logic [LIN_STEP_W-1:0] LINEAR_STEP_RST = 17'd13107;
	localparam logic [ANG_STEP_W-1:0] ANGLE_STEP_RST  = 14'd1638;
	localparam logic signed [31:0]    RADIUS_RST      = 32'sd655360;

	localparam logic signed [16:0] PI_Q13      = 17'sd25736;
	localparam logic signed [16:0] TWO_PI_Q13  = 17'sd51472;
	localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
	localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

	typedef struct packed {
		logic key_up;
		logic key_down;
		logic key_left;
		logic key_right;
		logic key_raise;
		logic key_lower;
		logic key_tilt_up;
		logic key_tilt_down;
		logic key_turn_left;
		logic key_turn_right;
		logic key_closer;
		logic key_farther;
	} in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EL_INIT,
		ST_EL_RUN,
		ST_EL_SAVE,
		ST_AZ_INIT,
		ST_AZ_RUN,
		ST_AZ_SAVE,
		ST_MUL,
		ST_DONE
	} state_e;

	typedef enum logic [2:0] {
		MSEL_CE_SA,
		MSEL_CE_CA,
		MSEL_SE_R,
		MSEL_TX_R,
		MSEL_TZ_R
	} msel_e;

	typedef struct packed {
		logic  update;
		logic  cor_init;
		logic  cor_sel;
		logic  cor_step;
		logic  cor_save;
		logic  mul_issue;
		msel_e mul_sel;
		logic  wb_en;
		msel_e wb_sel;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic cor_last;
	} sts_t;

	function automatic logic signed [32:0] atan_q30(input logic [ITER_W-1:0] i);
		case (i)
			5'd0:    atan_q30 = 33'sh03243F6A8;
			5'd1:    atan_q30 = 33'sh01DAC6705;
			5'd2:    atan_q30 = 33'sh00FADBAFC;
			5'd3:    atan_q30 = 33'sh007F56EA6;
			5'd4:    atan_q30 = 33'sh003FEAB76;
			5'd5:    atan_q30 = 33'sh001FFD55B;
			5'd6:    atan_q30 = 33'sh000FFFAAA;
			5'd7:    atan_q30 = 33'sh0007FFF55;
			5'd8:    atan_q30 = 33'sh0003FFFEA;
			5'd9:    atan_q30 = 33'sh0001FFFFD;
			5'd10:   atan_q30 = 33'sh0000FFFFF;
			5'd11:   atan_q30 = 33'sh00007FFFF;
			5'd12:   atan_q30 = 33'sh00003FFFF;
			5'd13:   atan_q30 = 33'sh00001FFFF;
			5'd14:   atan_q30 = 33'sh00000FFFF;
			5'd15:   atan_q30 = 33'sh000007FFF;
			5'd16:   atan_q30 = 33'sh000003FFF;
			5'd17:   atan_q30 = 33'sh000001FFF;
			5'd18:   atan_q30 = 33'sh000000FFF;
			5'd19:   atan_q30 = 33'sh0000007FF;
			5'd20:   atan_q30 = 33'sh0000003FF;
			5'd21:   atan_q30 = 33'sh0000001FF;
			5'd22:   atan_q30 = 33'sh0000000FF;
			5'd23:   atan_q30 = 33'sh00000007F;
			default: atan_q30 = 33'sh000000000;
		endcase
	endfunction

endpackage

// ----- rtl/orbit_camera_position_update.sv -----
// Orbit camera position update.
// Input channel (in_valid/in_ready/in_data): one transaction per frame holds
// twelve key flags. Keys move the look point and radius by linear_step, tilt
// and turn the two angles by angle_step (wrapped into [-pi, pi)), then the
// camera position look + r*(cos el sin az, sin el, cos el cos az) is produced.
// Output channel (out_valid/out_ready/out_data): one transaction per input,
// signed Q16.16 x, y, z, saturated.
// Configuration: cfg_we writes cfg_wdata to register cfg_idx at the clock
// edge (0 = linear_step, 1 = angle_step); write only while the block is idle.
// One shared iterative CORDIC unit runs both angles back to back, then one
// shared multiplier does five products; no new transaction is accepted until
// that sequence is through.
// The output register holds a finished result while the receiver stalls; a
// new transaction is accepted meanwhile and its result waits in the done
// state until the output register frees.
// Reset: look point and angles clear to zero, radius 10.0, steps to 0.2.
module orbit_camera_position_update #(
	parameter int CORDIC_ITERATIONS = ocpu_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_idx,
	input  logic [ocpu_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  ocpu_pkg::in_t              in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output ocpu_pkg::out_t             out_data
);

	ocpu_pkg::cmd_t cmd;
	ocpu_pkg::sts_t sts;

	// sequencer: accept, two rotations, multiply steps, hand off
	ocpu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// state registers, CORDIC, multiplier and output register
	ocpu_dp #(
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

// ----- rtl/ocpu_cordic.sv -----
module ocpu_cordic #(
	parameter int ITERS = ocpu_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               init,
	input  logic               step,
	input  logic signed [15:0] angle,
	output logic               last,
	output logic signed [32:0] sin_q30,
	output logic signed [32:0] cos_q30
);

	localparam int N = (ITERS > ocpu_pkg::ATAN_LEN) ? ocpu_pkg::ATAN_LEN : ITERS;
	localparam logic [ocpu_pkg::ITER_W-1:0] LAST_I = ocpu_pkg::ITER_W'(N - 1);

	logic signed [32:0] x_q, y_q, z_q;
	logic [ocpu_pkg::ITER_W-1:0] i_q;
	logic flip_q;

	logic signed [16:0] a_ext, a_red;
	logic               flip_d;
	logic signed [32:0] z0, dx, dy, at;

	// fold the angle into [-pi/2, pi/2]; the results of a folded angle are negated afterwards
	always_comb begin
		a_ext  = 17'(angle);
		a_red  = a_ext;
		flip_d = 1'b0;
		if (a_ext > ocpu_pkg::HALF_PI_Q13) begin
			a_red  = a_ext - ocpu_pkg::PI_Q13;
			flip_d = 1'b1;
		end else if (a_ext < -ocpu_pkg::HALF_PI_Q13) begin
			a_red  = a_ext + ocpu_pkg::PI_Q13;
			flip_d = 1'b1;
		end
		z0 = {a_red[15:0], 17'b0};
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = ocpu_pkg::atan_q30(i_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			flip_q <= 1'b0;
		end else if (init) begin
			i_q    <= '0;
			flip_q <= flip_d;
		end else if (step) begin
			i_q    <= i_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (init) begin
			x_q <= ocpu_pkg::CORDIC_GAIN_Q30;
			y_q <= '0;
			z_q <= z0;
		end else if (step) begin
			if (!z_q[32]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign last    = (i_q == LAST_I);
	assign sin_q30 = flip_q ? -y_q : y_q;
	assign cos_q30 = flip_q ? -x_q : x_q;

endmodule

// ----- rtl/ocpu_dp.sv -----
module ocpu_dp #(
	parameter int CORDIC_ITERATIONS = ocpu_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_idx,
	input  logic [ocpu_pkg::CFG_W-1:0] cfg_wdata,
	input  ocpu_pkg::in_t              in_data,
	input  ocpu_pkg::cmd_t             cmd,
	output ocpu_pkg::sts_t             sts,
	output ocpu_pkg::out_t             out_data
);

	logic [ocpu_pkg::LIN_STEP_W-1:0] lin_step_q;
	logic [ocpu_pkg::ANG_STEP_W-1:0] ang_step_q;
	logic signed [31:0] look_q [3];
	logic signed [15:0] el_q, az_q;
	logic signed [31:0] rad_q;
	logic signed [32:0] se_q, ce_q, sa_q, ca_q, tx_q, tz_q;
	logic signed [65:0] prod_q;
	ocpu_pkg::out_t     res_q, out_q;

	logic signed [32:0] sin_w, cos_w, opa, opb;
	logic signed [35:0] sh;
	logic               cor_last;

	function automatic logic signed [31:0] sat37(input logic signed [36:0] v);
		if (v > 37'sd2147483647)       sat37 = 32'sh7FFFFFFF;
		else if (v < -37'sd2147483648) sat37 = 32'sh80000000;
		else                           sat37 = v[31:0];
	endfunction

	function automatic logic signed [31:0] step_sat(input logic signed [31:0] v,
			input logic plus, input logic minus, input logic [16:0] st);
		logic signed [36:0] s;
		s = 37'(v);
		if (plus && !minus)      s = s + $signed({20'b0, st});
		else if (minus && !plus) s = s - $signed({20'b0, st});
		step_sat = sat37(s);
	endfunction

	function automatic logic signed [15:0] step_wrap(input logic signed [15:0] v,
			input logic plus, input logic minus, input logic [13:0] st);
		logic signed [16:0] a;
		a = 17'(v);
		if (plus && !minus)      a = a + $signed({3'b0, st});
		else if (minus && !plus) a = a - $signed({3'b0, st});
		if (a >= ocpu_pkg::PI_Q13)       a = a - ocpu_pkg::TWO_PI_Q13;
		else if (a < -ocpu_pkg::PI_Q13)  a = a + ocpu_pkg::TWO_PI_Q13;
		step_wrap = a[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_step_q <= ocpu_pkg::LINEAR_STEP_RST;
			ang_step_q <= ocpu_pkg::ANGLE_STEP_RST;
			look_q[0]  <= '0;
			look_q[1]  <= '0;
			look_q[2]  <= '0;
			el_q       <= '0;
			az_q       <= '0;
			rad_q      <= ocpu_pkg::RADIUS_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					ocpu_pkg::REG_LINEAR_STEP: lin_step_q <= cfg_wdata;
					ocpu_pkg::REG_ANGLE_STEP:  ang_step_q <= cfg_wdata[ocpu_pkg::ANG_STEP_W-1:0];
					default: ;
				endcase
			end
			if (cmd.update) begin
				look_q[0] <= step_sat(look_q[0], in_data.key_right, in_data.key_left, lin_step_q);
				look_q[1] <= step_sat(look_q[1], in_data.key_raise, in_data.key_lower, lin_step_q);
				look_q[2] <= step_sat(look_q[2], in_data.key_up, in_data.key_down, lin_step_q);
				el_q <= step_wrap(el_q, in_data.key_tilt_up, in_data.key_tilt_down, ang_step_q);
				az_q <= step_wrap(az_q, in_data.key_turn_left, in_data.key_turn_right,
					ang_step_q);
				rad_q <= step_sat(rad_q, in_data.key_farther, in_data.key_closer, lin_step_q);
			end
		end
	end

	ocpu_cordic #(
		.ITERS(CORDIC_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.init   (cmd.cor_init),
		.step   (cmd.cor_step),
		.angle  ((cmd.cor_sel == ocpu_pkg::SEL_AZ) ? az_q : el_q),
		.last   (cor_last),
		.sin_q30(sin_w),
		.cos_q30(cos_w)
	);

	assign sts.cor_last = cor_last;

	// one shared multiplier, registered product
	always_comb begin
		case (cmd.mul_sel)
			ocpu_pkg::MSEL_CE_SA: begin opa = ce_q; opb = sa_q;       end
			ocpu_pkg::MSEL_CE_CA: begin opa = ce_q; opb = ca_q;       end
			ocpu_pkg::MSEL_SE_R:  begin opa = se_q; opb = 33'(rad_q); end
			ocpu_pkg::MSEL_TX_R:  begin opa = tx_q; opb = 33'(rad_q); end
			ocpu_pkg::MSEL_TZ_R:  begin opa = tz_q; opb = 33'(rad_q); end
			default:              begin opa = ce_q; opb = sa_q;       end
		endcase
		sh = prod_q[65:30];
	end

	always_ff @(posedge clk) begin
		if (cmd.cor_save) begin
			if (cmd.cor_sel == ocpu_pkg::SEL_AZ) begin
				sa_q <= sin_w;
				ca_q <= cos_w;
			end else begin
				se_q <= sin_w;
				ce_q <= cos_w;
			end
		end
		if (cmd.mul_issue)
			prod_q <= opa * opb;
		if (cmd.wb_en) begin
			case (cmd.wb_sel)
				ocpu_pkg::MSEL_CE_SA: tx_q <= sh[32:0];
				ocpu_pkg::MSEL_CE_CA: tz_q <= sh[32:0];
				ocpu_pkg::MSEL_SE_R:  res_q.pos_y <= sat37(37'(sh) + 37'(look_q[1]));
				ocpu_pkg::MSEL_TX_R:  res_q.pos_x <= sat37(37'(sh) + 37'(look_q[0]));
				ocpu_pkg::MSEL_TZ_R:  res_q.pos_z <= sat37(37'(sh) + 37'(look_q[2]));
				default: ;
			endcase
		end
		if (cmd.out_load)
			out_q <= res_q;
	end

	assign out_data = out_q;

endmodule

// ----- rtl/ocpu_ctrl.sv -----
module ocpu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  ocpu_pkg::sts_t sts,
	output ocpu_pkg::cmd_t cmd
);

	ocpu_pkg::state_e state_q, state_d;
	logic [2:0] mul_k_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ocpu_pkg::ST_IDLE:    if (in_valid) state_d = ocpu_pkg::ST_EL_INIT;
			ocpu_pkg::ST_EL_INIT: state_d = ocpu_pkg::ST_EL_RUN;
			ocpu_pkg::ST_EL_RUN:  if (sts.cor_last) state_d = ocpu_pkg::ST_EL_SAVE;
			ocpu_pkg::ST_EL_SAVE: state_d = ocpu_pkg::ST_AZ_INIT;
			ocpu_pkg::ST_AZ_INIT: state_d = ocpu_pkg::ST_AZ_RUN;
			ocpu_pkg::ST_AZ_RUN:  if (sts.cor_last) state_d = ocpu_pkg::ST_AZ_SAVE;
			ocpu_pkg::ST_AZ_SAVE: state_d = ocpu_pkg::ST_MUL;
			ocpu_pkg::ST_MUL:     if (mul_k_q == 3'(ocpu_pkg::MUL_STEPS)) state_d = ocpu_pkg::ST_DONE;
			ocpu_pkg::ST_DONE:    if (out_free) state_d = ocpu_pkg::ST_IDLE;
			default:              state_d = ocpu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = ocpu_pkg::MSEL_CE_SA;
		cmd.wb_sel   = ocpu_pkg::MSEL_CE_SA;
		in_ready     = 1'b0;
		case (state_q)
			ocpu_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.update = in_valid;
			end
			ocpu_pkg::ST_EL_INIT: begin
				cmd.cor_init = 1'b1;
				cmd.cor_sel  = ocpu_pkg::SEL_EL;
			end
			ocpu_pkg::ST_EL_RUN: begin
				cmd.cor_step = 1'b1;
				cmd.cor_sel  = ocpu_pkg::SEL_EL;
			end
			ocpu_pkg::ST_EL_SAVE: begin
				cmd.cor_save = 1'b1;
				cmd.cor_sel  = ocpu_pkg::SEL_EL;
			end
			ocpu_pkg::ST_AZ_INIT: begin
				cmd.cor_init = 1'b1;
				cmd.cor_sel  = ocpu_pkg::SEL_AZ;
			end
			ocpu_pkg::ST_AZ_RUN: begin
				cmd.cor_step = 1'b1;
				cmd.cor_sel  = ocpu_pkg::SEL_AZ;
			end
			ocpu_pkg::ST_AZ_SAVE: begin
				cmd.cor_save = 1'b1;
				cmd.cor_sel  = ocpu_pkg::SEL_AZ;
			end
			ocpu_pkg::ST_MUL: begin
				cmd.mul_issue = (mul_k_q < 3'(ocpu_pkg::MUL_STEPS));
				cmd.mul_sel   = ocpu_pkg::msel_e'(mul_k_q);
				cmd.wb_en     = (mul_k_q != 3'd0);
				cmd.wb_sel    = ocpu_pkg::msel_e'(mul_k_q - 3'd1);
			end
			ocpu_pkg::ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ocpu_pkg::ST_IDLE;
			mul_k_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ocpu_pkg::ST_MUL)
				mul_k_q <= mul_k_q + 3'd1;
			else
				mul_k_q <= '0;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending transaction");
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ocpu_pkg::ST_EL_INIT))
		else $error("accepted transaction did not start the elevation rotation");
	a_mul_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ocpu_pkg::ST_MUL) |-> (mul_k_q <= 3'(ocpu_pkg::MUL_STEPS)))
		else $error("multiply step counter overran");
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ocpu_pkg::ST_DONE))
		else $error("result raised outside the done state");
`endif

endmodule
